FILE: sv/itps_pkg.sv
// ----------------------------------------------------------------------------
// itps_pkg: injector test pulse sequencer shared types and constants
// State encoding, sequencer state record, configuration record, tick flags
// and the clamp limits used by the step logic.
// ----------------------------------------------------------------------------
package itps_pkg;

  // register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_ON      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_OFF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_HOLDOFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_DELAY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_PULSE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd6;

  // clamp limits
  localparam logic [10:0] FILL_LIMIT    = 11'd1500;
  localparam logic [11:0] HOLDOFF_LIMIT = 12'd3000;
  localparam logic [12:0] BUDGET_LIMIT  = 13'd5000;
  localparam logic [16:0] PAUSE_LIMIT   = 17'd50000;
  localparam logic [15:0] PULSE10_MAX   = 16'd6553;
  localparam logic [15:0] INJECT_SAT    = 16'd65535;

  // reported state codes
  localparam logic [2:0] CODE_IDLE   = 3'd0;
  localparam logic [2:0] CODE_START  = 3'd1;
  localparam logic [2:0] CODE_ON     = 3'd2;
  localparam logic [2:0] CODE_OFF    = 3'd3;
  localparam logic [2:0] CODE_STOP   = 3'd4;
  localparam logic [2:0] CODE_END    = 3'd5;
  localparam logic [2:0] CODE_RECONF = 3'd6;
  localparam logic [2:0] CODE_FILL   = 3'd7;

  // sequencer state, one-hot
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_START  = 8'b0000_0010,
    ST_ON     = 8'b0000_0100,
    ST_OFF    = 8'b0000_1000,
    ST_STOP   = 8'b0001_0000,
    ST_END    = 8'b0010_0000,
    ST_RECONF = 8'b0100_0000,
    ST_FILL   = 8'b1000_0000
  } itps_main_t;

  typedef struct packed {
    logic test_enable;
    logic actuator_change;
    logic first_fill_request;
    logic first_fill_done;
  } itps_flags_t;

  typedef struct packed {
    logic [15:0] pulse_on_time;
    logic [15:0] pulse_off_time;
    logic [15:0] total_test_ticks;
    logic [15:0] idle_holdoff_ticks;
    logic [15:0] first_fill_delay;
    logic [15:0] first_fill_pulse;
    logic [15:0] sample_period;
  } itps_cfg_t;

  typedef struct packed {
    itps_main_t  main;
    logic        fill_phase;
    logic [15:0] inject;
    logic [12:0] budget;
    logic [15:0] pause;
    logic [11:0] holdoff;
    logic [10:0] countdown;
    logic        relay;
    logic        complete;
  } itps_state_t;

  // one-hot state to reported code
  function automatic logic [2:0] state_code(input itps_main_t s);
    logic [2:0] c;
    case (s)
      ST_IDLE:   c = CODE_IDLE;
      ST_START:  c = CODE_START;
      ST_ON:     c = CODE_ON;
      ST_OFF:    c = CODE_OFF;
      ST_STOP:   c = CODE_STOP;
      ST_END:    c = CODE_END;
      ST_RECONF: c = CODE_RECONF;
      default:   c = CODE_FILL;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/itps_in_if.sv
// ----------------------------------------------------------------------------
// itps_in_if: tick channel
// Valid/ready channel carrying the four flags of one periodic tick.
// ----------------------------------------------------------------------------
interface itps_in_if;
  logic valid;
  logic ready;
  logic test_enable;
  logic actuator_change;
  logic first_fill_request;
  logic first_fill_done;

  modport source (
    output valid, test_enable, actuator_change, first_fill_request, first_fill_done,
    input  ready
  );
  modport sink (
    input  valid, test_enable, actuator_change, first_fill_request, first_fill_done,
    output ready
  );
endinterface

FILE: sv/itps_out_if.sv
// ----------------------------------------------------------------------------
// itps_out_if: result channel
// Valid/ready channel carrying the sequencer status after one tick.
// ----------------------------------------------------------------------------
interface itps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  test_state;
  logic        first_fill_phase;
  logic [15:0] inject_time;
  logic        power_relay_on;
  logic        test_complete;

  modport source (
    output valid, test_state, first_fill_phase, inject_time, power_relay_on, test_complete,
    input  ready
  );
  modport sink (
    input  valid, test_state, first_fill_phase, inject_time, power_relay_on, test_complete,
    output ready
  );
endinterface

FILE: sv/itps_step.sv
// ----------------------------------------------------------------------------
// itps_step: next-state logic for one tick
// Computes the sequencer state after one tick from the current state, the
// configuration and the tick flags. Purely combinational.
// ----------------------------------------------------------------------------
module itps_step (
  input  itps_pkg::itps_state_t st,
  input  itps_pkg::itps_cfg_t   cfg,
  input  itps_pkg::itps_flags_t flags,
  output itps_pkg::itps_state_t st_nxt
);

  logic [15:0] sp;
  logic [16:0] sp_ext;
  logic [16:0] on_off_sum;
  logic [16:0] ph_sum;
  logic [16:0] ph_diff;
  logic [15:0] pause_load;
  logic [11:0] holdoff_load;
  logic [12:0] budget_load;
  logic [16:0] delay_p1;
  logic [10:0] fill_load;
  logic [10:0] pulse_clamp;
  logic [18:0] pulse_x10;
  logic [15:0] pulse_inject;
  logic        en;
  logic        abort;
  logic        start_ok;

  // clamped loads and shared arithmetic
  always_comb begin
    sp         = cfg.sample_period;
    sp_ext     = {1'b0, sp};
    on_off_sum = {1'b0, cfg.pulse_on_time} + {1'b0, cfg.pulse_off_time};
    ph_sum     = {1'b0, st.inject} + {1'b0, cfg.pulse_off_time};
    ph_diff    = ph_sum - sp_ext;
    if (ph_sum > sp_ext) begin
      pause_load = (ph_diff > itps_pkg::PAUSE_LIMIT) ? itps_pkg::PAUSE_LIMIT[15:0]
                                                      : ph_diff[15:0];
    end else begin
      pause_load = '0;
    end
    holdoff_load = (cfg.idle_holdoff_ticks > {4'b0, itps_pkg::HOLDOFF_LIMIT})
                 ? itps_pkg::HOLDOFF_LIMIT : cfg.idle_holdoff_ticks[11:0];
    budget_load  = (cfg.total_test_ticks > {3'b0, itps_pkg::BUDGET_LIMIT})
                 ? itps_pkg::BUDGET_LIMIT : cfg.total_test_ticks[12:0];
    delay_p1     = {1'b0, cfg.first_fill_delay} + 17'd1;
    fill_load    = (delay_p1 > {6'b0, itps_pkg::FILL_LIMIT})
                 ? itps_pkg::FILL_LIMIT : delay_p1[10:0];
    pulse_clamp  = (cfg.first_fill_pulse > {5'b0, itps_pkg::FILL_LIMIT})
                 ? itps_pkg::FILL_LIMIT : cfg.first_fill_pulse[10:0];
    // times ten as shift and add
    pulse_x10    = {cfg.first_fill_pulse, 3'b000} + {2'b00, cfg.first_fill_pulse, 1'b0};
    pulse_inject = (cfg.first_fill_pulse <= itps_pkg::PULSE10_MAX)
                 ? pulse_x10[15:0] : itps_pkg::INJECT_SAT;
    en       = flags.test_enable;
    abort    = !flags.test_enable || flags.actuator_change;
    start_ok = flags.test_enable && (st.holdoff == '0);
  end

  // state transitions
  always_comb begin
    st_nxt = st;
    case (st.main)
      itps_pkg::ST_IDLE: begin
        if (start_ok) begin
          st_nxt.main     = itps_pkg::ST_START;
          st_nxt.inject   = '0;
          st_nxt.relay    = 1'b1;
          st_nxt.complete = 1'b0;
        end else if (flags.first_fill_request) begin
          st_nxt.main       = itps_pkg::ST_FILL;
          st_nxt.fill_phase = 1'b0;
          st_nxt.countdown  = fill_load;
          st_nxt.relay      = 1'b0;
        end else if (st.holdoff != '0) begin
          st_nxt.holdoff = st.holdoff - 12'd1;
        end
      end
      itps_pkg::ST_START: begin
        if (en) begin
          st_nxt.main   = itps_pkg::ST_ON;
          st_nxt.inject = cfg.pulse_on_time;
          st_nxt.relay  = 1'b1;
          st_nxt.budget = budget_load;
        end
      end
      itps_pkg::ST_ON, itps_pkg::ST_OFF: begin
        if (abort) begin
          st_nxt.main     = itps_pkg::ST_STOP;
          st_nxt.inject   = '0;
          st_nxt.relay    = 1'b1;
          st_nxt.complete = 1'b0;
        end else if (st.budget <= 13'd1) begin
          st_nxt.main     = itps_pkg::ST_RECONF;
          st_nxt.inject   = '0;
          st_nxt.relay    = 1'b1;
          st_nxt.complete = 1'b1;
        end else begin
          st_nxt.budget = st.budget - 13'd1;
          if (st.main == itps_pkg::ST_ON) begin
            // on phase: count injection time down, then pause
            if (st.inject <= sp && on_off_sum > sp_ext) begin
              st_nxt.main   = itps_pkg::ST_OFF;
              st_nxt.pause  = pause_load;
              st_nxt.inject = '0;
            end else if (st.inject > sp) begin
              st_nxt.inject = st.inject - sp;
            end
          end else begin
            // off phase: count pause down, then next pulse
            if (st.pause <= sp) begin
              st_nxt.main   = itps_pkg::ST_ON;
              st_nxt.inject = cfg.pulse_on_time;
            end else begin
              st_nxt.pause = st.pause - sp;
            end
          end
        end
      end
      itps_pkg::ST_STOP: begin
        st_nxt.main     = itps_pkg::ST_IDLE;
        st_nxt.inject   = '0;
        st_nxt.relay    = 1'b0;
        st_nxt.complete = 1'b0;
        st_nxt.holdoff  = holdoff_load;
      end
      itps_pkg::ST_END: begin
        if (en) begin
          st_nxt.main     = itps_pkg::ST_IDLE;
          st_nxt.inject   = '0;
          st_nxt.relay    = 1'b0;
          st_nxt.complete = 1'b0;
          st_nxt.holdoff  = holdoff_load;
        end
      end
      itps_pkg::ST_RECONF: begin
        st_nxt.main     = itps_pkg::ST_END;
        st_nxt.relay    = 1'b0;
        st_nxt.complete = 1'b1;
      end
      default: begin
        // first fill: delay, one long pulse, back to idle, or to start when a start is allowed
        if (start_ok) begin
          st_nxt.main     = itps_pkg::ST_START;
          st_nxt.inject   = '0;
          st_nxt.relay    = 1'b1;
          st_nxt.complete = 1'b0;
        end else if (flags.first_fill_done || st.countdown == '0) begin
          st_nxt.main     = itps_pkg::ST_IDLE;
          st_nxt.inject   = '0;
          st_nxt.relay    = 1'b0;
          st_nxt.complete = 1'b0;
        end else if (!st.fill_phase && st.countdown == 11'd1) begin
          st_nxt.fill_phase = 1'b1;
          st_nxt.relay      = 1'b1;
          st_nxt.inject     = pulse_inject;
          st_nxt.countdown  = pulse_clamp;
        end else begin
          st_nxt.countdown = st.countdown - 11'd1;
        end
      end
    endcase
  end

endmodule

FILE: sv/injector_test_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// injector_test_pulse_sequencer: injector actuator test sequencer
// Steps the eight-state injector test (holdoff, on/off pulsing, first fill)
// once per tick and reports the resulting status.
// ----------------------------------------------------------------------------
// One tick is taken per clock cycle while out_ch does not stall. A transfer
// on in_ch lands in an input register; once the result register is free, a
// single pass of next-state logic updates the sequencer state and loads the
// result register, so ticks may follow back to back. A stall on out_ch
// holds the result register and, once the input register is also full,
// drops in_ch.ready. Configuration writes through cfg_we/cfg_index/cfg_wdata
// take effect on the next tick; an index beyond the register list is ignored.
module injector_test_pulse_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  itps_in_if.sink                         in_ch,
  itps_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [itps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_wdata
);

  itps_pkg::itps_cfg_t   cfg_r;
  itps_pkg::itps_state_t state_r;
  itps_pkg::itps_state_t state_nxt;
  itps_pkg::itps_flags_t flags_r;
  logic                  s1_valid_r;
  logic                  out_valid_r;
  logic [2:0]            out_state_r;
  logic                  out_phase_r;
  logic [15:0]           out_inject_r;
  logic                  out_relay_r;
  logic                  out_complete_r;
  logic                  out_free;
  logic                  s1_advance;
  logic                  in_xfer;

  // handshake
  assign out_free   = !out_valid_r || out_ch.ready;
  assign s1_advance = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_xfer    = in_ch.valid && in_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pulse_on_time:      16'd0,
                 pulse_off_time:     16'd0,
                 total_test_ticks:   16'd0,
                 idle_holdoff_ticks: 16'd0,
                 first_fill_delay:   16'd0,
                 first_fill_pulse:   16'd0,
                 sample_period:      16'd1};
    end else if (cfg_we) begin
      case (cfg_index)
        itps_pkg::REG_PULSE_ON:      cfg_r.pulse_on_time      <= cfg_wdata;
        itps_pkg::REG_PULSE_OFF:     cfg_r.pulse_off_time     <= cfg_wdata;
        itps_pkg::REG_TOTAL_TICKS:   cfg_r.total_test_ticks   <= cfg_wdata;
        itps_pkg::REG_IDLE_HOLDOFF:  cfg_r.idle_holdoff_ticks <= cfg_wdata;
        itps_pkg::REG_FILL_DELAY:    cfg_r.first_fill_delay   <= cfg_wdata;
        itps_pkg::REG_FILL_PULSE:    cfg_r.first_fill_pulse   <= cfg_wdata;
        itps_pkg::REG_SAMPLE_PERIOD: cfg_r.sample_period      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      flags_r.test_enable        <= in_ch.test_enable;
      flags_r.actuator_change    <= in_ch.actuator_change;
      flags_r.first_fill_request <= in_ch.first_fill_request;
      flags_r.first_fill_done    <= in_ch.first_fill_done;
    end
  end

  // next-state logic
  itps_step u_step (
    .st     (state_r),
    .cfg    (cfg_r),
    .flags  (flags_r),
    .st_nxt (state_nxt)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{main:       itps_pkg::ST_IDLE,
                   fill_phase: 1'b0,
                   inject:     16'd0,
                   budget:     13'd0,
                   pause:      16'd0,
                   holdoff:    12'd0,
                   countdown:  11'd0,
                   relay:      1'b0,
                   complete:   1'b0};
    end else if (s1_advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_state_r    <= itps_pkg::state_code(state_nxt.main);
      out_phase_r    <= state_nxt.fill_phase;
      out_inject_r   <= state_nxt.inject;
      out_relay_r    <= state_nxt.relay;
      out_complete_r <= state_nxt.complete;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.test_state       = out_state_r;
  assign out_ch.first_fill_phase = out_phase_r;
  assign out_ch.inject_time      = out_inject_r;
  assign out_ch.power_relay_on   = out_relay_r;
  assign out_ch.test_complete    = out_complete_r;

endmodule

FILE: sv/itps_checker.sv
// ----------------------------------------------------------------------------
// itps_checker: port-level checks for the injector test sequencer
// Watches the result channel for status combinations the sequencer must
// never report, and for a held result under back-pressure.
// ----------------------------------------------------------------------------
module itps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  test_state,
  input logic [15:0] inject_time,
  input logic        power_relay_on,
  input logic        test_complete
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(test_state) && $stable(inject_time))
    else $error("result changed while stalled");

  // idle reports nothing driven
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && test_state == itps_pkg::CODE_IDLE
      |-> inject_time == 16'd0 && !power_relay_on && !test_complete)
    else $error("idle with relay, injection or completion set");

  // relay held on through the running test states
  a_relay_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (test_state == itps_pkg::CODE_START || test_state == itps_pkg::CODE_ON ||
                  test_state == itps_pkg::CODE_OFF || test_state == itps_pkg::CODE_STOP ||
                  test_state == itps_pkg::CODE_RECONF)
      |-> power_relay_on)
    else $error("relay off during running test");

  // end state: completed, relay off, no injection
  a_end_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && test_state == itps_pkg::CODE_END
      |-> test_complete && !power_relay_on && inject_time == 16'd0)
    else $error("end state with inconsistent status");

endmodule

bind injector_test_pulse_sequencer itps_checker u_itps_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .test_state     (out_ch.test_state),
  .inject_time    (out_ch.inject_time),
  .power_relay_on (out_ch.power_relay_on),
  .test_complete  (out_ch.test_complete)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: injector test pulse sequencer testbench
// Drives tick flags and register settings into the sequencer and checks each
// status transfer against a cycle-free model of the eight-state test sequence,
// under several sender idle and receiver stall rates.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [2:0]  test_state;
  logic        fill_phase;
  logic [15:0] inject_time;
  logic        relay;
  logic        complete;
} tick_status_t;

// tracks the sequencer state and holds the status expected for each tick
class tick_scoreboard;
  tick_status_t status_q[$];
  int unsigned  errors;

  // register copies
  int unsigned on_time, off_time, total_ticks, holdoff_ticks;
  int unsigned fill_delay, fill_pulse, period;

  // sequencer copy
  logic [2:0]  mode;
  int unsigned fill_ph, inject, budget, pause, holdoff, countdown, relay, complete;

  function new();
    on_time = 0; off_time = 0; total_ticks = 0; holdoff_ticks = 0;
    fill_delay = 0; fill_pulse = 0; period = 1;
    mode = itps_pkg::CODE_IDLE; fill_ph = 0; inject = 0; budget = 0; pause = 0;
    holdoff = 0; countdown = 0; relay = 0; complete = 0;
    errors = 0;
  endfunction

  function int unsigned umin(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function void write_reg(input logic [itps_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] v);
    case (idx)
      itps_pkg::REG_PULSE_ON:      on_time = v;
      itps_pkg::REG_PULSE_OFF:     off_time = v;
      itps_pkg::REG_TOTAL_TICKS:   total_ticks = v;
      itps_pkg::REG_IDLE_HOLDOFF:  holdoff_ticks = v;
      itps_pkg::REG_FILL_DELAY:    fill_delay = v;
      itps_pkg::REG_FILL_PULSE:    fill_pulse = v;
      itps_pkg::REG_SAMPLE_PERIOD: period = v;
      default: ;
    endcase
  endfunction

  function void enter_start();
    mode = itps_pkg::CODE_START; inject = 0; relay = 1; complete = 0;
  endfunction

  function void enter_idle(input bit reload);
    mode = itps_pkg::CODE_IDLE; inject = 0; relay = 0; complete = 0;
    if (reload) holdoff = umin(holdoff_ticks, itps_pkg::HOLDOFF_LIMIT);
  endfunction

  // abort and budget exits shared by the on and off phases
  function bit leave_pulsing(input bit en, input bit chg);
    if (!en || chg) begin
      mode = itps_pkg::CODE_STOP; inject = 0; relay = 1; complete = 0;
      return 1;
    end
    if (budget <= 1) begin
      mode = itps_pkg::CODE_RECONF; inject = 0; relay = 1; complete = 1;
      return 1;
    end
    return 0;
  endfunction

  // advance one tick and queue the status it produces
  function void note_tick(input itps_pkg::itps_flags_t f);
    bit en, chg, req, done;
    int unsigned sum;
    tick_status_t want;
    en = f.test_enable;
    chg = f.actuator_change;
    req = f.first_fill_request;
    done = f.first_fill_done;
    case (mode)
      itps_pkg::CODE_IDLE: begin
        if (en && holdoff == 0) begin
          enter_start();
        end else if (req) begin
          mode = itps_pkg::CODE_FILL;
          fill_ph = 0;
          countdown = umin(fill_delay + 1, itps_pkg::FILL_LIMIT);
          relay = 0;
        end else if (holdoff > 0) begin
          holdoff = holdoff - 1;
        end
      end
      itps_pkg::CODE_START: begin
        if (en) begin
          mode = itps_pkg::CODE_ON;
          inject = on_time;
          relay = 1;
          budget = umin(total_ticks, itps_pkg::BUDGET_LIMIT);
        end
      end
      itps_pkg::CODE_ON: begin
        if (!leave_pulsing(en, chg)) begin
          if (inject <= period && on_time + off_time > period) begin
            sum = inject + off_time;
            mode = itps_pkg::CODE_OFF;
            pause = (sum > period) ? umin(sum - period, itps_pkg::PAUSE_LIMIT) : 0;
            inject = 0;
          end else if (inject > period) begin
            inject = inject - period;
          end
          budget = budget - 1;
        end
      end
      itps_pkg::CODE_OFF: begin
        if (!leave_pulsing(en, chg)) begin
          if (pause <= period) begin
            mode = itps_pkg::CODE_ON;
            inject = on_time;
          end else begin
            pause = pause - period;
          end
          budget = budget - 1;
        end
      end
      itps_pkg::CODE_STOP: enter_idle(1);
      itps_pkg::CODE_END: if (en) enter_idle(1);
      itps_pkg::CODE_RECONF: begin
        mode = itps_pkg::CODE_END; relay = 0; complete = 1;
      end
      default: begin
        // first fill: delay, one long pulse, then back to idle, or to start when allowed
        if (en && holdoff == 0) begin
          enter_start();
        end else if (done || countdown < 1) begin
          enter_idle(0);
        end else if (fill_ph == 0 && countdown < 2) begin
          fill_ph = 1;
          relay = 1;
          inject = (fill_pulse <= itps_pkg::PULSE10_MAX) ? fill_pulse * 10
                                                         : itps_pkg::INJECT_SAT;
          countdown = umin(fill_pulse, itps_pkg::FILL_LIMIT);
        end else begin
          countdown = countdown - 1;
        end
      end
    endcase
    want.test_state = mode;
    want.fill_phase = fill_ph[0];
    want.inject_time = inject[15:0];
    want.relay = relay[0];
    want.complete = complete[0];
    status_q.push_back(want);
  endfunction

  function void compare(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  function void check_result(input tick_status_t got);
    tick_status_t want;
    if (status_q.size() == 0) begin
      $display("%0t: unexpected status transfer, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = status_q.pop_front();
    compare("test_state", want.test_state, got.test_state);
    compare("first_fill_phase", want.fill_phase, got.fill_phase);
    compare("inject_time", want.inject_time, got.inject_time);
    compare("power_relay_on", want.relay, got.relay);
    compare("test_complete", want.complete, got.complete);
  endfunction

  function int unsigned pending();
    return status_q.size();
  endfunction
endclass

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [itps_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // tick flag patterns
  localparam itps_pkg::itps_flags_t T_NONE = 4'b0000;
  localparam itps_pkg::itps_flags_t T_EN   = 4'b1000;
  localparam itps_pkg::itps_flags_t T_CHG  = 4'b0100;
  localparam itps_pkg::itps_flags_t T_REQ  = 4'b0010;
  localparam itps_pkg::itps_flags_t T_DONE = 4'b0001;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [itps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                    cfg_wdata;

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count = 0;

  tick_scoreboard sb;

  itps_in_if  in_ch ();
  itps_out_if out_ch ();

  injector_test_pulse_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // observe both channels at the rising edge
  always @(posedge clk) begin : observe
    tick_status_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_tick({in_ch.test_enable, in_ch.actuator_change,
                      in_ch.first_fill_request, in_ch.first_fill_done});
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.test_state, out_ch.first_fill_phase, out_ch.inject_time,
               out_ch.power_relay_on, out_ch.test_complete};
        sb.check_result(got);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic itps_pkg::itps_flags_t pick_flags(input int unsigned en_pct,
                                                       input int unsigned chg_pct,
                                                       input int unsigned req_pct,
                                                       input int unsigned done_pct);
    itps_pkg::itps_flags_t f;
    f.test_enable = ($urandom_range(99) < en_pct);
    f.actuator_change = ($urandom_range(99) < chg_pct);
    f.first_fill_request = ($urandom_range(99) < req_pct);
    f.first_fill_done = ($urandom_range(99) < done_pct);
    return f;
  endfunction

  // one tick transfer, with random idle cycles ahead of it
  task automatic send_tick(input itps_pkg::itps_flags_t f);
    itps_pkg::itps_flags_t noise;
    while ($urandom_range(99) < send_gap_pct) begin
      noise = pick_flags(50, 50, 50, 50);
      in_ch.valid = 1'b0;
      {in_ch.test_enable, in_ch.actuator_change,
       in_ch.first_fill_request, in_ch.first_fill_done} = noise;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    {in_ch.test_enable, in_ch.actuator_change,
     in_ch.first_fill_request, in_ch.first_fill_done} = f;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_many(input int unsigned count, input itps_pkg::itps_flags_t f);
    repeat (count) send_tick(f);
  endtask

  task automatic write_reg(input logic [itps_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_regs(input logic [15:0] on_t, input logic [15:0] off_t,
                              input logic [15:0] total, input logic [15:0] hold,
                              input logic [15:0] delay, input logic [15:0] pulse,
                              input logic [15:0] period);
    write_reg(itps_pkg::REG_PULSE_ON, on_t);
    write_reg(itps_pkg::REG_PULSE_OFF, off_t);
    write_reg(itps_pkg::REG_TOTAL_TICKS, total);
    write_reg(itps_pkg::REG_IDLE_HOLDOFF, hold);
    write_reg(itps_pkg::REG_FILL_DELAY, delay);
    write_reg(itps_pkg::REG_FILL_PULSE, pulse);
    write_reg(itps_pkg::REG_SAMPLE_PERIOD, period);
    // unmapped index must be ignored
    write_reg(REG_SPARE, 16'($urandom));
  endtask

  // wait until every expected status has come back
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_config();
    logic [15:0] pulse;
    case ($urandom_range(19))
      0: pulse = itps_pkg::PULSE10_MAX;
      1: pulse = itps_pkg::PULSE10_MAX + 16'd1;
      2: pulse = itps_pkg::INJECT_SAT;
      default: pulse = 16'($urandom_range(12));
    endcase
    program_regs(($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12)),
                 ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12)),
                 ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(40)),
                 16'($urandom_range(6)),
                 16'($urandom_range(8)),
                 pulse,
                 16'($urandom_range(4)));
  endtask

  // bursts of test runs, fill requests and noise
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    int unsigned profile;
    sent = 0;
    while (sent < n_items) begin
      profile = $urandom_range(9);
      burst = $urandom_range(40, 1);
      repeat (burst) begin
        case (profile)
          0, 1, 2, 3, 4, 5: send_tick(pick_flags(96, 2, 10, 15));
          6, 7:             send_tick(pick_flags(4, 10, 60, 4));
          8:                send_tick(pick_flags(50, 50, 50, 50));
          default:          send_tick(pick_flags(20, 5, 5, 5));
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = itps_pkg::REG_PULSE_ON;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    {in_ch.test_enable, in_ch.actuator_change,
     in_ch.first_fill_request, in_ch.first_fill_done} = T_NONE;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: start, pulsing, abort, holdoff, full run, end, first fill
    program_regs(16'd3, 16'd2, 16'd8, 16'd2, 16'd2, 16'd3, 16'd1);
    send_tick(T_NONE);
    send_tick(T_EN);
    send_tick(T_NONE);
    send_many(5, T_EN);
    send_tick(T_EN | T_CHG);
    send_tick(T_NONE);
    send_many(4, T_EN);
    send_many(9, T_EN);
    send_tick(T_NONE);
    send_tick(T_EN);
    send_tick(T_REQ);
    send_many(4, T_NONE);
    send_tick(T_DONE);
    drain();

    // directed: zero sample period, saturated pulse, start out of first fill
    program_regs(16'd0, 16'd0, 16'd4, 16'd0, 16'd0, itps_pkg::PULSE10_MAX + 16'd1, 16'd0);
    send_tick(T_REQ);
    send_tick(T_NONE);
    send_many(6, T_EN);
    send_tick(T_NONE);
    drain();
    program_regs(16'd5, 16'd0, 16'd3, 16'd0, 16'd1, itps_pkg::PULSE10_MAX, 16'd0);
    send_tick(T_REQ | T_DONE);
    send_tick(T_REQ);
    send_many(3, T_NONE);
    send_many(5, T_EN);
    send_tick(T_EN | T_CHG | T_REQ | T_DONE);
    drain();

    // settings past the clamps whose low bits alone would be small
    program_regs(16'd3, 16'd2, 16'h2001, 16'h1001, 16'h0800, 16'h0801, 16'd1);
    send_many(8, T_NONE);
    send_many(24, T_EN);
    send_tick(T_EN | T_CHG);
    send_many(6, T_EN);
    send_tick(T_REQ);
    send_many(4, T_NONE);
    drain();

    // every register at its top: budget, holdoff and fill delay all clamp
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (60) send_tick(pick_flags(100, 0, 50, 50));
    repeat (60) send_tick(pick_flags(100, 50, 0, 50));
    send_tick(T_EN | T_CHG);
    send_tick(T_NONE);
    send_tick(T_REQ);
    repeat (60) send_tick(pick_flags(50, 50, 50, 0));
    drain();

    // every register at zero
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(100);
    drain();

    // random settings under each idle/stall mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 66; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 66; end
        default: begin send_gap_pct = 9; recv_stall_pct = 9; end
      endcase
      for (int k = 0; k < 4; k++) begin
        random_config();
        run_random(90);
        drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: injector_test_pulse_sequencer.f
sv/itps_pkg.sv
sv/itps_in_if.sv
sv/itps_out_if.sv
sv/itps_step.sv
sv/injector_test_pulse_sequencer.sv
sv/itps_checker.sv
bench/tb_top.sv
